/* design/sipa_pkg.sv */
// Shared definitions for the serial image page assembler.
// Holds configuration defaults, register indexes, result kinds and the
// command and status types between controller and datapath. No dependencies.
`default_nettype none

package sipa_pkg;

   // Default page size in bytes; must be a multiple of four.
   localparam int unsigned PAGE_BYTES_DEFAULT = 64;

   // Reset values of the configuration registers.
   localparam logic [31:0] IMAGE_BASE_RESET  = 32'h0800_1000;
   localparam logic [31:0] IMAGE_LIMIT_RESET = 32'h0800_4000;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_BASE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_LIMIT = 2'd1;

   // Result kinds.
   localparam logic KIND_PAGE_WORD = 1'b0;
   localparam logic KIND_REJECT    = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic hdr_addr_wr;   // take a start address byte
      logic hdr_cnt_wr;    // take a byte count byte
      logic byte_wr;       // store a payload byte in the page buffer
      logic rd_en;         // read the current word of the page buffer
      logic word_adv;      // move to the next word of the page
      logic page_end;      // page finished: advance address, empty buffer
      logic show_reject;   // the result on offer is a reject
   } sipa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hdr_last;      // this header byte is the fourth of its field
      logic addr_bad;      // start address lies outside the accepted window
      logic count_zero;    // count completed by the current byte is zero
      logic page_end_byte; // the current payload byte closes a page
      logic word_last;     // the current word is the last of the page
      logic xfer_last;     // no payload bytes remain
   } sipa_status_type;

endpackage

`default_nettype wire

/* design/serial_image_page_assembler.sv */
// Top level of the serial image page assembler: controller plus datapath.
// Depends on sipa_pkg, sipa_ctrl and sipa_datapath.
//
// Usage. Received serial bytes enter on the req_ channel, one byte per
// transaction. Each transfer opens with a four-byte little-endian start
// address and a four-byte little-endian byte count. Payload bytes are then
// gathered into a page buffer of PAGE_BYTES bytes (a multiple of four).
// When the page is full, or the last counted byte arrives, the page leaves on
// the rsp_ channel as PAGE_BYTES/4 word transactions tagged with the page
// address, zero padded where the page is short. A start address outside
// [image_base, image_limit) yields a single reject transaction instead.
// A header or non-final payload byte is taken as soon as it is offered. A
// byte that closes a page is followed, for each word, by a read of the buffer
// memory into a register and then the offer of that word. No byte is taken
// while a page or reject is being delivered. A stalled receiver simply holds
// the current word.
// Reset returns the block to waiting for a start address and restores the
// register defaults; the buffer needs no clearing because bytes beyond the
// fill count always read as zero.
`default_nettype none

module serial_image_page_assembler #(
   parameter int unsigned PAGE_BYTES = sipa_pkg::PAGE_BYTES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_en,
   input  wire logic [sipa_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [31:0]                           csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_rx_byte,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_kind,
   output logic [31:0]                                rsp_page_address,
   output logic [3:0]                                 rsp_word_index,
   output logic [31:0]                                rsp_data_word,
   output logic                                       rsp_page_last,
   output logic                                       rsp_transfer_last
);
   import sipa_pkg::*;

   sipa_cmd_type    cmd;
   sipa_status_type status;

   // The controller owns the sequencing; the datapath owns all storage.
   sipa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sipa_datapath #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_kind          (rsp_kind),
      .rsp_page_address  (rsp_page_address),
      .rsp_word_index    (rsp_word_index),
      .rsp_data_word     (rsp_data_word),
      .rsp_page_last     (rsp_page_last),
      .rsp_transfer_last (rsp_transfer_last)
   );

   // Input is never taken while a result is on offer.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("byte accepted while a result is on offer");

   // A reject is always a single transaction closing both page and transfer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_REJECT)) |-> (rsp_page_last && rsp_transfer_last))
      else $error("reject without last flags");

   // The end of a transfer is always the end of a page.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_transfer_last) |-> rsp_page_last)
      else $error("transfer end inside a page");

   // After the final word of a page the block returns to taking bytes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_page_last) |=> (!rsp_valid && req_ready))
      else $error("block did not return to input after a page");

endmodule

`default_nettype wire

/* design/sipa_datapath.sv */
// Datapath of the serial image page assembler: header registers, counters,
// the page buffer memory and the result fields. Depends on sipa_pkg and is
// driven by sipa_ctrl through the command struct.
`default_nettype none

module sipa_datapath #(
   parameter int unsigned PAGE_BYTES = sipa_pkg::PAGE_BYTES_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_write_en,
   input  wire logic [sipa_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [31:0]                              csr_wdata,
   input  wire logic [7:0]                               req_rx_byte,
   input  wire sipa_pkg::sipa_cmd_type                   cmd,
   output sipa_pkg::sipa_status_type                     status,
   output logic                                          rsp_kind,
   output logic [31:0]                                   rsp_page_address,
   output logic [3:0]                                    rsp_word_index,
   output logic [31:0]                                   rsp_data_word,
   output logic                                          rsp_page_last,
   output logic                                          rsp_transfer_last
);
   import sipa_pkg::*;

   localparam int unsigned WORDS = PAGE_BYTES / 4;
   localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned FW    = $clog2(PAGE_BYTES + 1);

   logic [31:0]   base_ff,  base_in;
   logic [31:0]   limit_ff, limit_in;
   logic [1:0]    hc_ff,    hc_in;
   logic [31:0]   addr_ff,  addr_in;
   logic [31:0]   cnt_ff,   cnt_in;
   logic [FW-1:0] fill_ff,  fill_in;
   logic [WW-1:0] word_ff,  word_in;
   logic [31:0]   rdata_ff;
   logic [31:0]   masked;
   logic [31:0]   mem [WORDS];
   logic [WW-1:0] wr_word;
   logic [1:0]    wr_lane;

   always_comb begin
      base_in  = base_ff;
      limit_in = limit_ff;
      if (csr_write_en) begin
         if (csr_index == CSR_IMAGE_BASE) begin
            base_in = csr_wdata;
         end
         if (csr_index == CSR_IMAGE_LIMIT) begin
            limit_in = csr_wdata;
         end
      end
   end

   always_comb begin
      hc_in   = hc_ff;
      addr_in = addr_ff;
      cnt_in  = cnt_ff;
      fill_in = fill_ff;
      word_in = word_ff;
      if (cmd.hdr_addr_wr || cmd.hdr_cnt_wr) begin
         hc_in = hc_ff + 2'd1;
      end
      if (cmd.hdr_addr_wr) begin
         addr_in[hc_ff*8 +: 8] = req_rx_byte;
      end
      if (cmd.hdr_cnt_wr) begin
         cnt_in[hc_ff*8 +: 8] = req_rx_byte;
      end
      if (cmd.byte_wr) begin
         cnt_in  = cnt_ff - 32'd1;
         fill_in = fill_ff + FW'(1);
      end
      if (cmd.word_adv) begin
         word_in = word_ff + WW'(1);
      end
      if (cmd.page_end) begin
         addr_in = addr_ff + 32'(PAGE_BYTES);
         fill_in = '0;
         word_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= IMAGE_BASE_RESET;
         limit_ff <= IMAGE_LIMIT_RESET;
         hc_ff    <= '0;
         addr_ff  <= '0;
         cnt_ff   <= '0;
         fill_ff  <= '0;
         word_ff  <= '0;
      end else begin
         base_ff  <= base_in;
         limit_ff <= limit_in;
         hc_ff    <= hc_in;
         addr_ff  <= addr_in;
         cnt_ff   <= cnt_in;
         fill_ff  <= fill_in;
         word_ff  <= word_in;
      end
   end

   // Page buffer: one byte lane written per payload byte, one word read at a
   // time. Stale bytes beyond the fill count are masked to zero on the way out.
   assign wr_word = WW'(fill_ff >> 2);
   assign wr_lane = fill_ff[1:0];

   always_ff @(posedge clock) begin
      if (cmd.byte_wr) begin
         mem[wr_word][wr_lane*8 +: 8] <= req_rx_byte;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[word_ff];
      end
   end

   always_comb begin
      logic [FW-1:0] pos;
      for (int l = 0; l < 4; l++) begin
         pos = (FW'(word_ff) << 2) + FW'(l);
         masked[l*8 +: 8] = (pos < fill_ff) ? rdata_ff[l*8 +: 8] : 8'd0;
      end
   end

   always_comb begin
      status.hdr_last      = (hc_ff == 2'd3);
      status.addr_bad      = (addr_ff < base_ff) || (addr_ff >= limit_ff);
      status.count_zero    = (req_rx_byte == 8'd0) && (cnt_ff[23:0] == 24'd0);
      status.page_end_byte = (fill_ff == FW'(PAGE_BYTES - 1)) || (cnt_ff == 32'd1);
      status.word_last     = (word_ff == WW'(WORDS - 1));
      status.xfer_last     = (cnt_ff == 32'd0);
   end

   always_comb begin
      if (cmd.show_reject) begin
         rsp_kind          = KIND_REJECT;
         rsp_word_index    = 4'd0;
         rsp_data_word     = 32'd0;
         rsp_page_last     = 1'b1;
         rsp_transfer_last = 1'b1;
      end else begin
         rsp_kind          = KIND_PAGE_WORD;
         rsp_word_index    = 4'(word_ff);
         rsp_data_word     = masked;
         rsp_page_last     = status.word_last;
         rsp_transfer_last = status.word_last && status.xfer_last;
      end
      rsp_page_address = addr_ff;
   end

endmodule

`default_nettype wire

/* design/sipa_ctrl.sv */
// Controller of the serial image page assembler: the sequencing state
// machine. Depends on sipa_pkg; commands sipa_datapath by struct.
`default_nettype none

module sipa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire sipa_pkg::sipa_status_type status,
   output sipa_pkg::sipa_cmd_type     cmd
);
   import sipa_pkg::*;

   localparam logic [2:0] ST_ADDR   = 3'd0;
   localparam logic [2:0] ST_COUNT  = 3'd1;
   localparam logic [2:0] ST_DATA   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_SHOW   = 3'd4;
   localparam logic [2:0] ST_REJECT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_ADDR: begin
            req_ready       = 1'b1;
            cmd.hdr_addr_wr = req_fire;
            if (req_fire && status.hdr_last) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            req_ready      = 1'b1;
            cmd.hdr_cnt_wr = req_fire;
            if (req_fire && status.hdr_last) begin
               priority if (status.addr_bad) begin
                  state_in = ST_REJECT;
               end else if (status.count_zero) begin
                  state_in = ST_ADDR;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            req_ready   = 1'b1;
            cmd.byte_wr = req_fire;
            if (req_fire && status.page_end_byte) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_fire) begin
               if (status.word_last) begin
                  cmd.page_end = 1'b1;
                  state_in     = status.xfer_last ? ST_ADDR : ST_DATA;
               end else begin
                  cmd.word_adv = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         ST_REJECT: begin
            rsp_valid       = 1'b1;
            cmd.show_reject = 1'b1;
            if (rsp_fire) begin
               state_in = ST_ADDR;
            end
         end
         default: begin
            state_in = ST_ADDR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ADDR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* test/serial_image_page_assembler_tb.sv */
// Self-checking testbench for the serial image page assembler.
// Needs sipa_pkg and the serial_image_page_assembler RTL; reads no files and
// predicts every page word and reject transaction from its own model of the block.

module serial_image_page_assembler_tb;
   import sipa_pkg::*;

   localparam int unsigned PAGE_SIZE      = PAGE_BYTES_DEFAULT;
   localparam int unsigned PAGE_WORDS     = PAGE_SIZE / 4;
   // Pause for a page to drain with a prompt receiver; allow margin.
   localparam int unsigned SETTLE_CYCLES  = 2 * PAGE_WORDS + 12;
   // The longest correct stretch without a transaction is a sender gap, a
   // receiver stall on a word, or the settle pause between phases.
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   // One result transaction as the block presents it.
   typedef struct packed {
      logic        kind;
      logic [31:0] page_address;
      logic [3:0]  word_index;
      logic [31:0] data_word;
      logic        page_last;
      logic        transfer_last;
   } page_word_type;

   // Where the byte stream stands: start address, byte count or payload.
   typedef enum logic [1:0] {SEEK_ADDR, SEEK_COUNT, GATHER} rx_phase_type;

   // How the payload of a queued transfer is filled.
   typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_style_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_IMAGE_BASE;
   logic [31:0]                csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_kind;
   logic [31:0]                rsp_page_address;
   logic [3:0]                 rsp_word_index;
   logic [31:0]                rsp_data_word;
   logic                       rsp_page_last;
   logic                       rsp_transfer_last;

   serial_image_page_assembler #(
      .PAGE_BYTES(PAGE_SIZE)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_page_address (rsp_page_address),
      .rsp_word_index   (rsp_word_index),
      .rsp_data_word    (rsp_data_word),
      .rsp_page_last    (rsp_page_last),
      .rsp_transfer_last(rsp_transfer_last)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Byte stream waiting to be offered, and the page words still owed by the block.
   logic [7:0]    pending_bytes[$];
   page_word_type expected_words[$];
   int            bytes_queued = 0;
   int            error_count = 0;
   int            quiet_cycles = 0;
   int            req_gap = 0;
   int            rsp_stall = 0;
   logic          req_taken = 1'b0;
   // Once set, neither side idles any more: the closing part of the run.
   logic          steady = 1'b0;

   // The testbench's own view of the registers and of the block's state.
   logic [31:0]  cfg_base = IMAGE_BASE_RESET;
   logic [31:0]  cfg_limit = IMAGE_LIMIT_RESET;
   rx_phase_type rx_phase = SEEK_ADDR;
   logic [1:0]   hdr_pos = '0;
   logic [31:0]  page_addr = '0;
   logic [31:0]  xfer_left = '0;
   logic [7:0]   page_bytes[PAGE_SIZE];
   int unsigned  fill_count = 0;

   initial page_bytes = '{default: 8'h00};

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Advances the predicted state by one received byte and queues whatever
   // page words or reject the block owes for it.
   task automatic absorb_byte(input logic [7:0] rx);
      logic [31:0] word;
      case (rx_phase)
         SEEK_COUNT: begin
            if (hdr_pos == 2'd0)
               xfer_left = {24'h0, rx};
            else
               xfer_left[8*hdr_pos +: 8] = rx;
            hdr_pos = hdr_pos + 2'd1;
            // The start address is judged only once the whole header is in.
            if (hdr_pos == 2'd0) begin
               if (page_addr < cfg_base || page_addr >= cfg_limit) begin
                  expected_words.push_back('{KIND_REJECT, page_addr, 4'd0, 32'd0, 1'b1, 1'b1});
                  rx_phase = SEEK_ADDR;
               end else if (xfer_left == 32'd0) begin
                  rx_phase = SEEK_ADDR;
               end else begin
                  page_bytes = '{default: 8'h00};
                  fill_count = 0;
                  rx_phase = GATHER;
               end
            end
         end
         GATHER: begin
            page_bytes[fill_count] = rx;
            fill_count++;
            xfer_left = xfer_left - 32'd1;
            if (fill_count == PAGE_SIZE || xfer_left == 32'd0) begin
               for (int w = 0; w < PAGE_WORDS; w++) begin
                  word = {page_bytes[4*w+3], page_bytes[4*w+2],
                          page_bytes[4*w+1], page_bytes[4*w]};
                  expected_words.push_back('{KIND_PAGE_WORD, page_addr, w[3:0], word,
                                             w == PAGE_WORDS - 1,
                                             w == PAGE_WORDS - 1 && xfer_left == 32'd0});
               end
               // The page address runs on past the limit and wraps at 2^32.
               page_addr = page_addr + PAGE_SIZE;
               page_bytes = '{default: 8'h00};
               fill_count = 0;
               if (xfer_left == 32'd0)
                  rx_phase = SEEK_ADDR;
            end
         end
         default: begin
            if (hdr_pos == 2'd0)
               page_addr = {24'h0, rx};
            else
               page_addr[8*hdr_pos +: 8] = rx;
            hdr_pos = hdr_pos + 2'd1;
            if (hdr_pos == 2'd0)
               rx_phase = SEEK_COUNT;
         end
      endcase
   endtask

   task automatic check_word();
      page_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0b address %h word %0d",
                                   rsp_kind, rsp_page_address, rsp_word_index));
      end else begin
         want = expected_words.pop_front();
         if (rsp_kind !== want.kind)
            report_mismatch($sformatf("kind %b, expected %b", rsp_kind, want.kind));
         if (rsp_page_address !== want.page_address)
            report_mismatch($sformatf("page_address %h, expected %h",
                                      rsp_page_address, want.page_address));
         if (rsp_word_index !== want.word_index)
            report_mismatch($sformatf("word_index %0d, expected %0d",
                                      rsp_word_index, want.word_index));
         if (rsp_data_word !== want.data_word)
            report_mismatch($sformatf("data_word %h, expected %h (address %h word %0d)",
                                      rsp_data_word, want.data_word,
                                      want.page_address, want.word_index));
         if (rsp_page_last !== want.page_last)
            report_mismatch($sformatf("page_last %b, expected %b (word %0d)",
                                      rsp_page_last, want.page_last, want.word_index));
         if (rsp_transfer_last !== want.transfer_last)
            report_mismatch($sformatf("transfer_last %b, expected %b (address %h)",
                                      rsp_transfer_last, want.transfer_last,
                                      want.page_address));
      end
   endtask

   // Monitor. Everything is sampled at the rising edge. A result transaction
   // is checked before a byte accepted on the same edge is predicted, since
   // the result can only belong to an earlier byte. The watchdog counts edges
   // on which neither channel completes a transaction.
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_word();
         if (req_valid && req_ready)
            absorb_byte(req_rx_byte);
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Byte driver. A byte on offer is held until its transaction completes;
   // only then may the next byte follow, or an idle burst begin.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            if (!steady && $urandom_range(0, 5) == 0)
               req_gap = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Ready drops in random bursts, which can land on any word of a
   // page as well as on reject transactions.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady && $urandom_range(0, 7) == 0)
            rsp_stall = $urandom_range(1, 17);
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_IMAGE_BASE)
         cfg_base = value;
      else
         cfg_limit = value;
   endtask

   // Queues one transfer: the header, then the payload only if the block will
   // take it, that is if the start lies in the current window.
   task automatic queue_transfer(input logic [31:0] start, input logic [31:0] count,
                                 input fill_style_type fill);
      for (int i = 0; i < 4; i++)
         pending_bytes.push_back(start[8*i +: 8]);
      for (int i = 0; i < 4; i++)
         pending_bytes.push_back(count[8*i +: 8]);
      bytes_queued += 8;
      if (start >= cfg_base && start < cfg_limit) begin
         for (longint i = 0; i < count; i++) begin
            case (fill)
               FILL_ONES:  pending_bytes.push_back(8'hFF);
               FILL_ZEROS: pending_bytes.push_back(8'h00);
               default:    pending_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         bytes_queued += count;
      end
   endtask

   // Mostly well-formed transfers with random content inside the window, when
   // it is open; the rest are headers to be rejected, with arbitrary 32-bit counts.
   task automatic random_traffic(input int budget);
      int             stop_at;
      logic           window_open;
      logic [31:0]    start;
      logic [31:0]    count;
      logic [63:0]    room;
      fill_style_type fill;
      stop_at = bytes_queued + budget;
      while (bytes_queued < stop_at) begin
         window_open = cfg_base < cfg_limit;
         if (window_open && $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
               0: start = cfg_base;
               1: start = cfg_limit - 32'd1;
               default: start = cfg_base + ($urandom % (cfg_limit - cfg_base));
            endcase
            case ($urandom_range(0, 9))
               0:       count = 32'd0;
               1, 2:    count = $urandom_range(17, 80);
               default: count = $urandom_range(1, 16);
            endcase
         end else begin
            if (!window_open) begin
               start = $urandom;
            end else if (cfg_base != 32'd0 && $urandom_range(0, 1) == 0) begin
               start = $urandom_range(0, 1) ? cfg_base - 32'd1 : $urandom_range(cfg_base - 1, 0);
            end else begin
               room = 64'h1_0000_0000 - {32'h0, cfg_limit};
               if ($urandom_range(0, 1) != 0)
                  start = cfg_limit;
               else
                  start = cfg_limit + 32'(({32'h0, $urandom} % room));
            end
            count = $urandom;
         end
         case ($urandom_range(0, 7))
            0:       fill = FILL_ONES;
            1:       fill = FILL_ZEROS;
            default: fill = FILL_RANDOM;
         endcase
         queue_transfer(start, count, fill);
      end
   endtask

   // Waits until every queued byte has been taken and every owed result has
   // arrived, then gives the block time to finish any page it might still be
   // working on without a result yet owed.
   task automatic drain();
      while (pending_bytes.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] lo;
      logic [31:0] span;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, on the reset window [0x08001000, 0x08004000): just below
      // the base, a one-byte page at the base, a zero count at the top of the
      // window, the limit with an all-ones count, and four zero bytes inside.
      queue_transfer(IMAGE_BASE_RESET - 32'd1, 32'd5, FILL_RANDOM);
      queue_transfer(IMAGE_BASE_RESET, 32'd1, FILL_ONES);
      queue_transfer(IMAGE_LIMIT_RESET - 32'd1, 32'd0, FILL_RANDOM);
      queue_transfer(IMAGE_LIMIT_RESET, 32'hFFFF_FFFF, FILL_RANDOM);
      queue_transfer(IMAGE_BASE_RESET + 32'h100, 32'd4, FILL_ZEROS);
      drain();

      // Widest possible window: only the very top address is refused.
      write_csr(CSR_IMAGE_BASE, 32'h0000_0000);
      write_csr(CSR_IMAGE_LIMIT, 32'hFFFF_FFFF);
      random_traffic(8);
      drain();

      // Window at the top of the address space; a two-page transfer from
      // 0xFFFFFFC0 wraps its second page round to address zero.
      write_csr(CSR_IMAGE_BASE, 32'hFFFF_FF00);
      queue_transfer(32'hFFFF_FFC0, 32'd66, FILL_RANDOM);
      drain();

      // A random window somewhere in the address space.
      lo = $urandom;
      span = $urandom_range(1, 32'h1_0000);
      write_csr(CSR_IMAGE_BASE, lo);
      write_csr(CSR_IMAGE_LIMIT, (lo > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : lo + span);
      random_traffic(8);
      drain();

      // Base above the limit, then base equal to the limit: every start is refused.
      write_csr(CSR_IMAGE_BASE, 32'hFFFF_FFFF);
      write_csr(CSR_IMAGE_LIMIT, 32'h0000_0000);
      random_traffic(8);
      drain();
      lo = $urandom;
      write_csr(CSR_IMAGE_BASE, lo);
      write_csr(CSR_IMAGE_LIMIT, lo);
      random_traffic(8);
      drain();

      // Closing part at full rate on both sides, back on the reset window.
      steady = 1'b1;
      write_csr(CSR_IMAGE_BASE, IMAGE_BASE_RESET);
      write_csr(CSR_IMAGE_LIMIT, IMAGE_LIMIT_RESET);
      random_traffic(8);
      drain();

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
